[rtl/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and defaults for the LFU key/value cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam logic [4:0] CAP_RESET = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_HIT,
        ST_SCAN,
        ST_INS,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_HIT,
        CMD_INS
    } t_cmd_kind;

    // broadcast from the controller to every cell
    typedef struct packed {
        t_cmd_kind kind;
        logic      is_put;
        logic      evict;
    } t_cmd;

endpackage

[rtl/lfu_cache_key_value_top.sv]
// ----------------------------------------------------------------------------
// lfu_cache_key_value_top
// LFU key/value cache built as a row of entry cells with a search chain.
// ----------------------------------------------------------------------------
// Path: a hit goes ST_LOOK, ST_HIT, ST_DONE, then the output register; a get miss
//   or a put with zero capacity goes ST_LOOK, ST_DONE; a put miss goes ST_LOOK,
//   ST_SCAN (victim search rippling one cell per cycle), ST_INS, ST_DONE.
// Throughput: one item at a time; next item accepted once this one is handed
//   to the output register (which may still hold it while stalled).
// Reset: synchronous active low; clears entry valid bits, occupancy, FSM and
//   sets capacity to 16. Entry payload is not cleared.
module lfu_cache_key_value_top #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] key, [63:32] value
    input  logic [0:0]  s_axis_tuser,  // [0] opcode (0 get, 1 put)
    // response channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] found, [32:1] read_value, [33] evicted, [65:34] evicted_key, rest 0
    output logic [71:0] m_axis_tdata,
    // capacity write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    import lfu_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int MW = (OW > 5) ? OW : 5;
    localparam logic [MW-1:0] ENT_M = MW'(ENTRIES);
    localparam logic [OW-1:0] SCAN_LAST = OW'(ENTRIES - 1);

    t_state r_state, n_state;

    logic [4:0]    r_cap;
    logic [OW-1:0] r_occ;
    logic [OW-1:0] r_scan;

    // current item and its result
    logic          r_op;
    logic [31:0]   r_key;
    logic [31:0]   r_val;
    logic          r_hit;
    logic [IW-1:0] r_hrank;
    logic [31:0]   r_rd;
    logic          r_ev;
    logic [31:0]   r_evk;

    logic          r_ovalid;
    logic [71:0]   r_odata;

    // cell row
    t_cmd          cmd;
    logic [IW-1:0] ref_rank;
    logic [IW-1:0] target;
    logic          cell_match [ENTRIES];
    logic [31:0]   cell_value [ENTRIES];
    logic [IW-1:0] cell_rank  [ENTRIES];

    logic                  cv [ENTRIES+1];
    logic [COUNT_BITS-1:0] cc [ENTRIES+1];
    logic [IW-1:0]         cr [ENTRIES+1];
    logic [31:0]           ck [ENTRIES+1];
    logic [IW-1:0]         ci [ENTRIES+1];
    logic                  fv [ENTRIES+1];
    logic [IW-1:0]         fi [ENTRIES+1];

    logic          hit;
    logic [31:0]   hit_value;
    logic [IW-1:0] hit_rank;
    logic [MW-1:0] cap_eff;
    logic          cap_zero;
    logic          evict;
    logic          load_out;

    // chain head: no candidate, no free slot yet
    assign cv[0] = 1'b0;
    assign cc[0] = '0;
    assign cr[0] = '0;
    assign ck[0] = '0;
    assign ci[0] = '0;
    assign fv[0] = 1'b0;
    assign fi[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_cell #(
            .ENTRIES    (ENTRIES),
            .COUNT_BITS (COUNT_BITS),
            .IDX        (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_key        (r_key),
            .i_value      (r_val),
            .i_ref_rank   (ref_rank),
            .i_target     (target),
            .o_match      (cell_match[g]),
            .o_value      (cell_value[g]),
            .o_rank       (cell_rank[g]),
            .i_cand_valid (cv[g]),
            .i_cand_cnt   (cc[g]),
            .i_cand_rank  (cr[g]),
            .i_cand_key   (ck[g]),
            .i_cand_idx   (ci[g]),
            .i_free_valid (fv[g]),
            .i_free_idx   (fi[g]),
            .o_cand_valid (cv[g+1]),
            .o_cand_cnt   (cc[g+1]),
            .o_cand_rank  (cr[g+1]),
            .o_cand_key   (ck[g+1]),
            .o_cand_idx   (ci[g+1]),
            .o_free_valid (fv[g+1]),
            .o_free_idx   (fi[g+1])
        );
    end

    // keys are unique among valid entries, so at most one cell matches
    always_comb begin
        hit       = 1'b0;
        hit_value = '0;
        hit_rank  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit       = hit | cell_match[i];
            hit_value = hit_value | (cell_match[i] ? cell_value[i] : 32'd0);
            hit_rank  = hit_rank  | (cell_match[i] ? cell_rank[i]  : '0);
        end
    end

    assign cap_eff  = (MW'(r_cap) > ENT_M) ? ENT_M : MW'(r_cap);
    assign cap_zero = (cap_eff == '0);
    // used in ST_INS, once the ST_SCAN state has let the chain tail settle
    assign evict    = (MW'(r_occ) >= cap_eff) && cv[ENTRIES];
    assign target   = evict ? ci[ENTRIES] : fi[ENTRIES];
    assign ref_rank = (r_state == ST_HIT) ? r_hrank : cr[ENTRIES];
    assign load_out = (r_state == ST_DONE) && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        cmd.kind   = CMD_NONE;
        cmd.is_put = r_op;
        cmd.evict  = evict;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_LOOK;
            end
            ST_LOOK: begin
                if (r_op && cap_zero) n_state = ST_DONE;
                else if (hit)         n_state = ST_HIT;
                else if (r_op)        n_state = ST_SCAN;
                else                  n_state = ST_DONE;
            end
            ST_HIT: begin
                cmd.kind = CMD_HIT;
                n_state  = ST_DONE;
            end
            ST_SCAN: begin
                if (r_scan == SCAN_LAST) n_state = ST_INS;
            end
            ST_INS: begin
                cmd.kind = CMD_INS;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (load_out) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_occ <= '0;
        end else begin
            if (i_cfg_valid) r_cap <= i_cfg_data;
            if (r_state == ST_INS && !evict) r_occ <= r_occ + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op  <= s_axis_tuser[0];
            r_key <= s_axis_tdata[31:0];
            r_val <= s_axis_tdata[63:32];
        end
        r_scan <= (r_state == ST_SCAN) ? r_scan + 1'b1 : '0;
        case (r_state)
            ST_LOOK: begin
                r_hit   <= hit;
                r_hrank <= hit_rank;
                r_ev    <= 1'b0;
                r_evk   <= '0;
                if (hit) r_rd <= (r_op && !cap_zero) ? r_val : hit_value;
                else     r_rd <= '0;
            end
            ST_INS: begin
                r_rd  <= r_val;
                r_ev  <= evict;
                r_evk <= evict ? ck[ENTRIES] : 32'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_odata <= {6'd0, r_evk, r_ev, r_rd, r_hit};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // occupancy never passes the number of cells
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(ENTRIES))
        else $error("occupancy above entry count");

    // an insert only follows a lookup that missed
    a_ins_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS) |-> !r_hit && r_op)
        else $error("insert after a hit");

    // a result with an eviction never reports the key as found
    a_ev_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> !(m_axis_tdata[33] && m_axis_tdata[0]))
        else $error("eviction on a hit");

endmodule

[rtl/lfu_cell.sv]
// ----------------------------------------------------------------------------
// lfu_cell
// One cache entry plus one stage of the victim / free-slot search chain.
// ----------------------------------------------------------------------------
module lfu_cell #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16,
    parameter int IDX        = 0,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lfu_pkg::t_cmd         i_cmd,
    input  logic [31:0]           i_key,
    input  logic [31:0]           i_value,
    input  logic [IW-1:0]         i_ref_rank,
    input  logic [IW-1:0]         i_target,
    output logic                  o_match,
    output logic [31:0]           o_value,
    output logic [IW-1:0]         o_rank,
    input  logic                  i_cand_valid,
    input  logic [COUNT_BITS-1:0] i_cand_cnt,
    input  logic [IW-1:0]         i_cand_rank,
    input  logic [31:0]           i_cand_key,
    input  logic [IW-1:0]         i_cand_idx,
    input  logic                  i_free_valid,
    input  logic [IW-1:0]         i_free_idx,
    output logic                  o_cand_valid,
    output logic [COUNT_BITS-1:0] o_cand_cnt,
    output logic [IW-1:0]         o_cand_rank,
    output logic [31:0]           o_cand_key,
    output logic [IW-1:0]         o_cand_idx,
    output logic                  o_free_valid,
    output logic [IW-1:0]         o_free_idx
);
    import lfu_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [IW-1:0]         MY_IDX  = IW'(IDX);

    logic                  r_valid;
    logic [31:0]           r_key;
    logic [31:0]           r_value;
    logic [COUNT_BITS-1:0] r_count;
    logic [IW-1:0]         r_rank;

    logic                  r_cv;
    logic [COUNT_BITS-1:0] r_cc;
    logic [IW-1:0]         r_cr;
    logic [31:0]           r_ck;
    logic [IW-1:0]         r_ci;
    logic                  r_fv;
    logic [IW-1:0]         r_fi;

    logic match;
    logic is_target;
    logic better;

    assign match     = r_valid && (r_key == i_key);
    assign is_target = (i_target == MY_IDX);
    assign better    = r_valid && (!i_cand_valid || (r_count < i_cand_cnt) ||
                       ((r_count == i_cand_cnt) && (r_rank > i_cand_rank)));

    assign o_match = match;
    assign o_value = r_value;
    assign o_rank  = r_rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.kind == CMD_INS && is_target) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.kind)
            CMD_HIT: begin
                if (match) begin
                    if (i_cmd.is_put) r_value <= i_value;
                    if (r_count != CNT_MAX) r_count <= r_count + 1'b1;
                    r_rank <= '0;
                end else if (r_valid && r_rank < i_ref_rank) begin
                    r_rank <= r_rank + 1'b1;
                end
            end
            CMD_INS: begin
                if (is_target) begin
                    r_key   <= i_key;
                    r_value <= i_value;
                    r_count <= COUNT_BITS'(1);
                    r_rank  <= '0;
                end else if (r_valid && (!i_cmd.evict || r_rank < i_ref_rank)) begin
                    // ranks behind the victim drop by one and rise by one again
                    r_rank <= r_rank + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // search chain stage
    always_ff @(posedge i_clk) begin
        if (better) begin
            r_cv <= 1'b1;
            r_cc <= r_count;
            r_cr <= r_rank;
            r_ck <= r_key;
            r_ci <= MY_IDX;
        end else begin
            r_cv <= i_cand_valid;
            r_cc <= i_cand_cnt;
            r_cr <= i_cand_rank;
            r_ck <= i_cand_key;
            r_ci <= i_cand_idx;
        end
        r_fv <= i_free_valid | ~r_valid;
        r_fi <= i_free_valid ? i_free_idx : MY_IDX;
    end

    assign o_cand_valid = r_cv;
    assign o_cand_cnt   = r_cc;
    assign o_cand_rank  = r_cr;
    assign o_cand_key   = r_ck;
    assign o_cand_idx   = r_ci;
    assign o_free_valid = r_fv;
    assign o_free_idx   = r_fi;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LFU key/value cache: random get/put traffic
// against a behavioral cache model, over several capacity settings, with
// bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb;

    localparam int ENTRIES   = lfu_pkg::ENTRIES_DEF;
    localparam int COUNT_MAX = (1 << lfu_pkg::COUNT_BITS_DEF) - 1;
    localparam int LIMIT     = 2000000;
    localparam logic OP_GET  = 1'b0;
    localparam logic OP_PUT  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] key;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } t_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // [31:0] key, [63:32] value
    logic [0:0]  s_axis_tuser = '0;   // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // [0] found, [32:1] value, [33] evicted, [65:34] key
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;

    lfu_cache_key_value_top dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // model state
    logic        m_valid [ENTRIES];
    logic [31:0] m_key   [ENTRIES];
    logic [31:0] m_val   [ENTRIES];
    int          m_cnt   [ENTRIES];
    int          m_rank  [ENTRIES];
    int          m_occ;
    logic [4:0]  m_cap = 5'd16;

    t_req  pending_reqs[$];
    t_rsp  expected_rsps[$];
    int    errors = 0, sent = 0, got = 0, cycles = 0, evictions = 0, hits = 0;
    int    gap = 0, burst = 0;
    logic [31:0] keypool[$];

    task automatic report(input string what, input logic [31:0] act, input logic [31:0] exp);
        errors++;
        $display("mismatch #%0d %s: got %h want %h", got, what, act, exp);
    endtask

    function automatic t_rsp lfu_access(input t_req r);
        t_rsp o = '0;
        int e = -1, cap, v, ins;
        cap = (m_cap > ENTRIES) ? ENTRIES : m_cap;
        for (int i = 0; i < ENTRIES; i++)
            if (e < 0 && m_valid[i] && m_key[i] == r.key) e = i;
        o.found = (e >= 0);
        if (r.op == OP_PUT && cap == 0) begin
            if (e >= 0) o.read_value = m_val[e];
        end else if (e >= 0) begin
            if (r.op == OP_PUT) m_val[e] = r.value;
            o.read_value = m_val[e];
            if (m_cnt[e] < COUNT_MAX) m_cnt[e]++;
            for (int i = 0; i < ENTRIES; i++)
                if (m_valid[i] && i != e && m_rank[i] < m_rank[e]) m_rank[i]++;
            m_rank[e] = 0;
        end else if (r.op == OP_PUT) begin
            if (m_occ >= cap) begin
                v = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (m_valid[i] && (v < 0 || m_cnt[i] < m_cnt[v] ||
                        (m_cnt[i] == m_cnt[v] && m_rank[i] > m_rank[v]))) v = i;
                if (v >= 0) begin
                    o.evicted = 1'b1;
                    o.evicted_key = m_key[v];
                    m_valid[v] = 1'b0;
                    for (int i = 0; i < ENTRIES; i++)
                        if (m_valid[i] && m_rank[i] > m_rank[v]) m_rank[i]--;
                    if (m_occ > 0) m_occ--;
                end
            end
            ins = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (ins < 0 && !m_valid[i]) ins = i;
            if (ins >= 0) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (m_valid[i]) m_rank[i]++;
                m_valid[ins] = 1'b1;
                m_key[ins] = r.key;
                m_val[ins] = r.value;
                m_cnt[ins] = 1;
                m_rank[ins] = 0;
                m_occ++;
                o.read_value = r.value;
            end
        end
        return o;
    endfunction

    // Driver: bursts of beats separated by random gaps.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_rsps.push_back(lfu_access(pending_reqs.pop_front()));
                sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap > 0) begin
                    gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_reqs[0].op;
                    s_axis_tdata  <= {pending_reqs[0].value, pending_reqs[0].key};
                    if (burst > 0) burst--;
                    else begin
                        burst = $urandom_range(0, 12);
                        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each response beat; receiver stalls in its own pattern.
    always @(posedge i_clk) begin
        t_rsp act, exp;
        cycles++;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                act.found       = m_axis_tdata[0];
                act.read_value  = m_axis_tdata[32:1];
                act.evicted     = m_axis_tdata[33];
                act.evicted_key = m_axis_tdata[65:34];
                got++;
                if (expected_rsps.size() == 0) begin
                    errors++;
                    $display("unexpected response beat %0d", got);
                end else begin
                    exp = expected_rsps.pop_front();
                    if (act.evicted) evictions++;
                    if (act.found) hits++;
                    if (act.found != exp.found) report("found", act.found, exp.found);
                    if (act.read_value != exp.read_value)
                        report("read_value", act.read_value, exp.read_value);
                    if (act.evicted != exp.evicted) report("evicted", act.evicted, exp.evicted);
                    if (act.evicted_key != exp.evicted_key)
                        report("evicted_key", act.evicted_key, exp.evicted_key);
                    if (m_axis_tdata[71:66] != '0) report("pad", m_axis_tdata[71:66], 0);
                end
            end
            // long no-stall stretches while bit 9 of cycles is set, else ~1/3 stall
            m_axis_tready <= (cycles[9]) ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [31:0] pick_key();
        if (keypool.size() > 0 && $urandom_range(0, 3) != 0)
            return keypool[$urandom_range(0, keypool.size() - 1)];
        return $urandom();
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (ENTRIES + 8) @(posedge i_clk);
    endtask

    task automatic write_cap(input logic [4:0] c);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= c;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        m_cap = c;
    endtask

    task automatic push(input logic op, input logic [31:0] k, input logic [31:0] v);
        pending_reqs.push_back('{op, k, v});
    endtask

    initial begin
        logic [4:0] caps[7];
        t_req r;
        caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd9};
        for (int i = 0; i < ENTRIES; i++) begin
            m_valid[i] = 1'b0; m_key[i] = '0; m_val[i] = '0; m_cnt[i] = 0; m_rank[i] = 0;
        end
        m_occ = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty get, extreme keys/values, hit, overwrite, eviction tie
        push(OP_GET, 32'h0, 32'h0);
        push(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        push(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        push(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push(OP_PUT, 32'h0, 32'h0);
        push(OP_GET, 32'h8000_0000, 32'h1234_5678);
        push(OP_PUT, 32'h7FFF_FFFF, 32'h5555_AAAA);
        push(OP_GET, 32'h1, 32'h0);
        for (int i = 0; i < 14; i++) push(OP_PUT, 32'h100 + i, ~i);
        push(OP_PUT, 32'hDEAD_BEEF, 32'h1);   // full: evicts least used, oldest
        wait_idle();

        // capacity phases; zero capacity and shrink below occupancy included
        for (int p = 0; p < 7; p++) begin
            write_cap(caps[p]);
            if (p == 1) begin
                // lower capacity with a full cache, then a put miss
                push(OP_PUT, 32'hCAFE_0001, 32'h2);
                push(OP_GET, 32'hCAFE_0001, 32'h0);
            end
            keypool.delete();
            for (int i = 0; i < 10 + p * 3; i++) keypool.push_back($urandom());
            for (int n = 0; n < 190; n++) begin
                r.op = ($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET;
                r.key = pick_key();
                r.value = $urandom();
                pending_reqs.push_back(r);
            end
            wait_idle();
        end

        // hammer one key toward a high use count, then force evictions around it
        write_cap(5'd3);
        for (int n = 0; n < 40; n++) push(OP_GET, 32'h8000_0000, 32'h0);
        for (int n = 0; n < 20; n++) push(OP_PUT, $urandom(), $urandom());
        wait_idle();

        $display("%0d requests sent, %0d responses checked (%0d hits, %0d evictions)",
                 sent, got, hits, evictions);
        $display("capacities 16,1,0,31,4,17,9,3 exercised with bursty traffic and stalls");
        if (errors == 0 && expected_rsps.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
